// ----- rtl/sqh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace classifier package
// Shared codes and types for the trace classifier and its heap level cells.
// ----------------------------------------------------------------------------
package sqh_pkg;

    localparam logic [1:0] FUNC_INSERT  = 2'd0;
    localparam logic [1:0] FUNC_REMOVE  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [2:0] VERDICT_STACK      = 3'd0;
    localparam logic [2:0] VERDICT_QUEUE      = 3'd1;
    localparam logic [2:0] VERDICT_HEAP       = 3'd2;
    localparam logic [2:0] VERDICT_IMPOSSIBLE = 3'd3;
    localparam logic [2:0] VERDICT_UNSURE     = 3'd4;

    localparam int FIT_STACK = 0;
    localparam int FIT_QUEUE = 1;
    localparam int FIT_HEAP  = 2;

    typedef enum logic [1:0] {
        HOP_INS   = 2'd0,
        HOP_FETCH = 2'd1,
        HOP_DEL   = 2'd2
    } t_hop;

    typedef struct packed {
        logic valid;
        t_hop op;
        logic live;
    } t_hctl;

endpackage

// ----- rtl/sqh_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace classifier channels
// Request channel carrying one trace operation and response channel carrying
// the verdict and consistency flags.
// ----------------------------------------------------------------------------
interface sqh_in_if #(
    parameter int VB = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic signed [VB-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink (input valid, func, value, output ready);
endinterface

interface sqh_out_if ();
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic       stack_fits;
    logic       queue_fits;
    logic       heap_fits;
    logic       overflow;

    modport source (output valid, verdict, stack_fits, queue_fits, heap_fits, overflow,
                    input ready);
    modport sink (input valid, verdict, stack_fits, queue_fits, heap_fits, overflow,
                  output ready);
endinterface

// ----- rtl/stack_queue_heap_trace_classifier_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack, queue and priority queue trace classifier
// Checks a trace of insert and remove requests against a stack, a queue and
// a max heap at once and reports which of them the trace still fits.
//
//   Port    Dir  Role      Contents
//   i_in    in   request   func, value
//   o_out   out  response  verdict, stack_fits, queue_fits, heap_fits, overflow
//
// The heap is a chain of L = clog2(DEPTH+1) level cells (11 at DEPTH 1024), each
// holding a request in its A and B registers; a heap walk passes the whole chain.
// An insert makes at most one walk; a remove makes a fetch walk, then a sift walk
// while the heap still fits and is not left empty. Restart and unused codes make none.
// Reset needs no clearing pass; requests are taken right after reset.
// A response still waiting in the output register holds the next request.
// ----------------------------------------------------------------------------
module stack_queue_heap_trace_classifier_top import sqh_pkg::*; #(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sqh_in_if.sink    i_in,
    sqh_out_if.source o_out
);

    localparam int VB   = VALUE_BITS;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int LV   = CW;
    localparam int PW   = LV - 1;
    localparam int AW_S = $clog2(DEPTH);
    localparam int LNW  = $clog2(CW);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
    localparam logic [AW_S-1:0] LAST_SLOT = AW_S'(DEPTH - 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_WAIT_F = 6'b000100,
        ST_EVAL   = 6'b001000,
        ST_WAIT_D = 6'b010000,
        ST_DONE   = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [1:0]           r_func, n_func;
    logic signed [VB-1:0] r_value, n_value;
    logic [CW-1:0]        r_scnt, n_scnt;
    logic [AW_S-1:0]      r_qhead, n_qhead;
    logic [AW_S-1:0]      r_qtail, n_qtail;
    logic [CW-1:0]        r_qcnt, n_qcnt;
    logic [CW-1:0]        r_hcnt, n_hcnt;
    logic [2:0]           r_fits, n_fits;
    logic                 r_ovf, n_ovf;
    logic                 r_busy, n_busy;
    logic signed [VB-1:0] r_top, n_top;
    logic signed [VB-1:0] r_last, n_last;

    t_hctl                r_tctl, n_tctl;
    logic signed [VB-1:0] r_tval, n_tval;
    logic [PW-1:0]        r_tpos, n_tpos;
    logic [CW-1:0]        r_tn, n_tn;
    logic [CW-1:0]        r_tpath, n_tpath;

    logic                 r_ovalid, n_ovalid;
    logic [2:0]           r_overdict, n_overdict;
    logic [2:0]           r_oflags, n_oflags;
    logic                 r_oovf, n_oovf;

    logic signed [VB-1:0] r_smem [DEPTH];
    logic signed [VB-1:0] r_qmem [DEPTH];
    logic signed [VB-1:0] r_srd;
    logic signed [VB-1:0] r_qrd;

    logic                 w_swe;
    logic                 w_qwe;
    logic                 w_rde;
    logic [CW-1:0]        w_stop;
    logic [CW-1:0]        w_hn;
    logic [LNW-1:0]       w_ln;
    logic [CW-1:0]        w_path;
    logic [AW_S-1:0]      w_qhead_nx;
    logic [AW_S-1:0]      w_qtail_nx;
    logic [2:0]           w_verdict;

    t_hctl                w_ctl   [LV+1];
    logic signed [VB-1:0] w_val   [LV+1];
    logic signed [VB-1:0] w_aux   [LV+1];
    logic [PW-1:0]        w_pos   [LV+1];
    logic [CW-1:0]        w_n     [LV+1];
    logic [CW-1:0]        w_path_l[LV+1];
    logic [PW-1:0]        w_kpos  [LV];
    logic [PW-1:0]        w_ppos  [LV];
    logic signed [VB-1:0] w_pair0 [LV];
    logic signed [VB-1:0] w_pair1 [LV];
    logic signed [VB-1:0] w_kid0  [LV];
    logic signed [VB-1:0] w_kid1  [LV];
    logic [LV:0]          w_linkv;

    assign w_ctl[0]    = r_tctl;
    assign w_val[0]    = r_tval;
    assign w_aux[0]    = r_tval;
    assign w_pos[0]    = r_tpos;
    assign w_n[0]      = r_tn;
    assign w_path_l[0] = r_tpath;

    for (genvar k = 0; k < LV; k++) begin : g_cell
        localparam int SIZE = (k == LV - 1) ? DEPTH - (1 << k) + 1 : (1 << k);

        if (k == 0) begin : g_root
            assign w_ppos[k] = '0;
        end else begin : g_inner
            assign w_ppos[k] = w_kpos[k-1];
        end

        if (k == LV - 1) begin : g_leaf
            assign w_kid0[k] = '0;
            assign w_kid1[k] = '0;
        end else begin : g_branch
            assign w_kid0[k] = w_pair0[k+1];
            assign w_kid1[k] = w_pair1[k+1];
        end

        sqh_cell #(
            .LEVEL  (k),
            .LEVELS (LV),
            .SIZE   (SIZE),
            .VB     (VB)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl[k]),
            .i_val     (w_val[k]),
            .i_aux     (w_aux[k]),
            .i_pos     (w_pos[k]),
            .i_n       (w_n[k]),
            .i_path    (w_path_l[k]),
            .i_par_pos (w_ppos[k]),
            .i_kid0    (w_kid0[k]),
            .i_kid1    (w_kid1[k]),
            .o_ctl     (w_ctl[k+1]),
            .o_val     (w_val[k+1]),
            .o_aux     (w_aux[k+1]),
            .o_pos     (w_pos[k+1]),
            .o_n       (w_n[k+1]),
            .o_path    (w_path_l[k+1]),
            .o_kid_pos (w_kpos[k]),
            .o_pair0   (w_pair0[k]),
            .o_pair1   (w_pair1[k])
        );
    end

    for (genvar k = 0; k <= LV; k++) begin : g_linkv
        assign w_linkv[k] = w_ctl[k].valid;
    end

    always_comb begin
        w_ln = '0;
        for (int j = 0; j < CW; j++) begin
            if (w_hn[j]) begin
                w_ln = LNW'(j);
            end
        end
    end

    assign w_hn       = r_hcnt + CW'(1);
    assign w_path     = w_hn << (LNW'(CW - 1) - w_ln);
    assign w_stop     = r_scnt - CW'(1);
    assign w_qhead_nx = (r_qhead == LAST_SLOT) ? '0 : r_qhead + AW_S'(1);
    assign w_qtail_nx = (r_qtail == LAST_SLOT) ? '0 : r_qtail + AW_S'(1);

    always_comb begin
        case (r_fits)
            3'b001:  w_verdict = VERDICT_STACK;
            3'b010:  w_verdict = VERDICT_QUEUE;
            3'b100:  w_verdict = VERDICT_HEAP;
            3'b000:  w_verdict = VERDICT_IMPOSSIBLE;
            default: w_verdict = VERDICT_UNSURE;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_value    = r_value;
        n_scnt     = r_scnt;
        n_qhead    = r_qhead;
        n_qtail    = r_qtail;
        n_qcnt     = r_qcnt;
        n_hcnt     = r_hcnt;
        n_fits     = r_fits;
        n_ovf      = r_ovf;
        n_busy     = r_busy;
        n_top      = r_top;
        n_last     = r_last;
        n_tctl     = '{valid: 1'b0, op: HOP_INS, live: 1'b0};
        n_tval     = r_tval;
        n_tpos     = r_tpos;
        n_tn       = r_tn;
        n_tpath    = r_tpath;
        n_ovalid   = r_ovalid;
        n_overdict = r_overdict;
        n_oflags   = r_oflags;
        n_oovf     = r_oovf;
        w_swe      = 1'b0;
        w_qwe      = 1'b0;
        w_rde      = 1'b0;

        if (w_linkv[LV]) begin
            n_busy = 1'b0;
            n_top  = w_val[LV];
            n_last = w_aux[LV];
        end
        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_func  = i_in.func;
                    n_value = i_in.value;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_func)
                    FUNC_INSERT: begin
                        if (r_fits[FIT_STACK]) begin
                            if (r_scnt == FULL_C) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_swe  = 1'b1;
                                n_scnt = r_scnt + CW'(1);
                            end
                        end
                        if (r_fits[FIT_QUEUE]) begin
                            if (r_qcnt == FULL_C) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_qwe   = 1'b1;
                                n_qtail = w_qtail_nx;
                                n_qcnt  = r_qcnt + CW'(1);
                            end
                        end
                        if (r_fits[FIT_HEAP]) begin
                            if (r_hcnt == FULL_C) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_tctl  = '{valid: 1'b1, op: HOP_INS, live: 1'b1};
                                n_tval  = r_value;
                                n_tpos  = '0;
                                n_tn    = w_hn;
                                n_tpath = w_path;
                                n_hcnt  = w_hn;
                                n_busy  = 1'b1;
                            end
                        end
                        n_state = ST_WAIT_D;
                    end
                    FUNC_REMOVE: begin
                        w_rde = 1'b1;
                        if (r_fits[FIT_HEAP] && (r_hcnt != '0)) begin
                            n_tctl = '{valid: 1'b1, op: HOP_FETCH, live: 1'b1};
                            n_tpos = '0;
                            n_tn   = r_hcnt;
                            n_busy = 1'b1;
                        end
                        n_state = ST_WAIT_F;
                    end
                    FUNC_RESTART: begin
                        n_scnt  = '0;
                        n_qhead = '0;
                        n_qtail = '0;
                        n_qcnt  = '0;
                        n_hcnt  = '0;
                        n_fits  = 3'b111;
                        n_ovf   = 1'b0;
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_WAIT_F: begin
                if (!r_busy) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_fits[FIT_STACK]) begin
                    if ((r_scnt == '0) || (r_srd != r_value)) begin
                        n_fits[FIT_STACK] = 1'b0;
                    end else begin
                        n_scnt = w_stop;
                    end
                end
                if (r_fits[FIT_QUEUE]) begin
                    if ((r_qcnt == '0) || (r_qrd != r_value)) begin
                        n_fits[FIT_QUEUE] = 1'b0;
                    end else begin
                        n_qhead = w_qhead_nx;
                        n_qcnt  = r_qcnt - CW'(1);
                    end
                end
                if (r_fits[FIT_HEAP]) begin
                    if ((r_hcnt == '0) || (r_top != r_value)) begin
                        n_fits[FIT_HEAP] = 1'b0;
                    end else begin
                        n_hcnt = r_hcnt - CW'(1);
                        if (r_hcnt != CW'(1)) begin
                            n_tctl = '{valid: 1'b1, op: HOP_DEL, live: 1'b1};
                            n_tval = r_last;
                            n_tpos = '0;
                            n_tn   = r_hcnt - CW'(1);
                            n_busy = 1'b1;
                        end
                    end
                end
                n_state = ST_WAIT_D;
            end
            ST_WAIT_D: begin
                if (!r_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid   = 1'b1;
                    n_overdict = w_verdict;
                    n_oflags   = r_fits;
                    n_oovf     = r_ovf;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_swe) begin
            r_smem[r_scnt[AW_S-1:0]] <= r_value;
        end
        if (w_rde) begin
            r_srd <= r_smem[w_stop[AW_S-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qwe) begin
            r_qmem[r_qtail] <= r_value;
        end
        if (w_rde) begin
            r_qrd <= r_qmem[r_qhead];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_scnt   <= '0;
            r_qhead  <= '0;
            r_qtail  <= '0;
            r_qcnt   <= '0;
            r_hcnt   <= '0;
            r_fits   <= 3'b111;
            r_ovf    <= 1'b0;
            r_busy   <= 1'b0;
            r_tctl   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scnt   <= n_scnt;
            r_qhead  <= n_qhead;
            r_qtail  <= n_qtail;
            r_qcnt   <= n_qcnt;
            r_hcnt   <= n_hcnt;
            r_fits   <= n_fits;
            r_ovf    <= n_ovf;
            r_busy   <= n_busy;
            r_tctl   <= n_tctl;
            r_ovalid <= n_ovalid;
        end
        r_func     <= n_func;
        r_value    <= n_value;
        r_top      <= n_top;
        r_last     <= n_last;
        r_tval     <= n_tval;
        r_tpos     <= n_tpos;
        r_tn       <= n_tn;
        r_tpath    <= n_tpath;
        r_overdict <= n_overdict;
        r_oflags   <= n_oflags;
        r_oovf     <= n_oovf;
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.verdict    = r_overdict;
    assign o_out.stack_fits = r_oflags[FIT_STACK];
    assign o_out.queue_fits = r_oflags[FIT_QUEUE];
    assign o_out.heap_fits  = r_oflags[FIT_HEAP];
    assign o_out.overflow   = r_oovf;

`ifndef SYNTHESIS
    a_one_heap_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_linkv))
        else $error("more than one heap request on the cell chain");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt <= FULL_C) && (r_qcnt <= FULL_C) && (r_hcnt <= FULL_C))
        else $error("structure count beyond capacity");

    a_idle_chain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!r_busy && (w_linkv == '0)))
        else $error("request taken while the heap chain is busy");

    a_fits_only_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_EXEC) |=> ((r_fits & ~$past(r_fits)) == 3'b000))
        else $error("consistency flag raised outside a restart");
`endif

endmodule

// ----- rtl/sqh_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heap level cell
// Holds one level of the max heap in a local memory. A heap request enters,
// reads this level (and the child pair for the level above), updates this
// level and leaves for the next cell through its A and B registers.
// ----------------------------------------------------------------------------
module sqh_cell import sqh_pkg::*; #(
    parameter int LEVEL  = 0,
    parameter int LEVELS = 11,
    parameter int SIZE   = 1,
    parameter int VB     = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_hctl                  i_ctl,
    input  logic signed [VB-1:0]   i_val,
    input  logic signed [VB-1:0]   i_aux,
    input  logic [LEVELS-2:0]      i_pos,
    input  logic [LEVELS-1:0]      i_n,
    input  logic [LEVELS-1:0]      i_path,
    input  logic [LEVELS-2:0]      i_par_pos,
    input  logic signed [VB-1:0]   i_kid0,
    input  logic signed [VB-1:0]   i_kid1,
    output t_hctl                  o_ctl,
    output logic signed [VB-1:0]   o_val,
    output logic signed [VB-1:0]   o_aux,
    output logic [LEVELS-2:0]      o_pos,
    output logic [LEVELS-1:0]      o_n,
    output logic [LEVELS-1:0]      o_path,
    output logic [LEVELS-2:0]      o_kid_pos,
    output logic signed [VB-1:0]   o_pair0,
    output logic signed [VB-1:0]   o_pair1
);

    localparam int PW    = LEVELS - 1;
    localparam int CW    = LEVELS;
    localparam int AW    = (SIZE > 2) ? $clog2(SIZE) : 1;
    localparam int MEM_N = (SIZE > 2) ? SIZE : 2;
    localparam int PBIT  = (LEVEL < LEVELS - 1) ? LEVELS - 2 - LEVEL : 0;
    localparam logic [CW:0] KID_BASE = (CW + 1)'(1) << (LEVEL + 1);

    logic signed [VB-1:0] r_mem [MEM_N];
    logic signed [VB-1:0] r_rd0;
    logic signed [VB-1:0] r_rd1;

    t_hctl                r_actl;
    logic signed [VB-1:0] r_aval;
    logic signed [VB-1:0] r_aaux;
    logic [PW-1:0]        r_apos;
    logic [CW-1:0]        r_an;
    logic [CW-1:0]        r_apath;

    t_hctl                r_bctl;
    logic signed [VB-1:0] r_bval;
    logic signed [VB-1:0] r_baux;
    logic [PW-1:0]        r_bpos;
    logic [CW-1:0]        r_bn;
    logic [CW-1:0]        r_bpath;

    t_hctl                n_bctl;
    logic signed [VB-1:0] n_bval;
    logic signed [VB-1:0] n_baux;
    logic [PW-1:0]        n_bpos;

    logic [AW-1:0]        w_own_addr;
    logic [AW-1:0]        w_addr0;
    logic [AW-1:0]        w_addr1;
    logic                 w_we;
    logic signed [VB-1:0] w_wdata;
    logic [CW-1:0]        w_tier;
    logic                 w_at_tgt;
    logic                 w_deeper;
    logic [CW:0]          w_kid_idx;
    logic                 w_e0;
    logic                 w_e1;
    logic                 w_pick;
    logic signed [VB-1:0] w_kid_val;

    always_comb begin
        if (i_ctl.op == HOP_FETCH) begin
            w_own_addr = (LEVEL == 0) ? '0 : i_n[AW-1:0];
        end else begin
            w_own_addr = i_pos[AW-1:0];
        end
        w_addr0 = i_ctl.valid ? w_own_addr : i_par_pos[AW-1:0];
        w_addr1 = i_par_pos[AW-1:0] | AW'(1);
    end

    assign o_kid_pos = i_pos << 1;

    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[w_addr0];
        r_rd1 <= r_mem[w_addr1];
        if (w_we) begin
            r_mem[r_apos[AW-1:0]] <= w_wdata;
        end
    end

    always_comb begin
        w_tier    = r_an >> LEVEL;
        w_at_tgt  = (w_tier == CW'(1));
        w_deeper  = (w_tier > CW'(1));
        w_kid_idx = KID_BASE + ((CW + 1)'(r_apos) << 1);
        w_e0      = (w_kid_idx <= (CW + 1)'(r_an));
        w_e1      = ((w_kid_idx + (CW + 1)'(1)) <= (CW + 1)'(r_an));
        w_pick    = w_e1 && (i_kid1 > i_kid0);
        w_kid_val = w_pick ? i_kid1 : i_kid0;

        n_bctl  = r_actl;
        n_bval  = r_aval;
        n_baux  = r_aaux;
        n_bpos  = r_apos;
        w_we    = 1'b0;
        w_wdata = r_aval;

        case (r_actl.op)
            HOP_INS: begin
                if (w_deeper) begin
                    n_bpos = (r_apos << 1) | PW'(r_apath[PBIT]);
                    if (r_rd0 < r_aval) begin
                        w_we   = r_actl.valid;
                        n_bval = r_rd0;
                    end
                end else if (w_at_tgt) begin
                    w_we = r_actl.valid;
                end
            end
            HOP_FETCH: begin
                if (LEVEL == 0) begin
                    n_bval = r_rd0;
                end
                if (w_at_tgt) begin
                    n_baux = r_rd0;
                end
            end
            HOP_DEL: begin
                if (r_actl.live) begin
                    w_we = r_actl.valid;
                    if (w_e0 && (w_kid_val > r_aval)) begin
                        w_wdata = w_kid_val;
                        n_bpos  = (r_apos << 1) | PW'(w_pick);
                    end else begin
                        n_bctl.live = 1'b0;
                    end
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_actl <= '0;
            r_bctl <= '0;
        end else begin
            r_actl <= i_ctl;
            r_bctl <= n_bctl;
        end
        r_aval  <= i_val;
        r_aaux  <= i_aux;
        r_apos  <= i_pos;
        r_an    <= i_n;
        r_apath <= i_path;
        r_bval  <= n_bval;
        r_baux  <= n_baux;
        r_bpos  <= n_bpos;
        r_bn    <= r_an;
        r_bpath <= r_apath;
    end

    assign o_ctl   = r_bctl;
    assign o_val   = r_bval;
    assign o_aux   = r_baux;
    assign o_pos   = r_bpos;
    assign o_n     = r_bn;
    assign o_path  = r_bpath;
    assign o_pair0 = r_rd0;
    assign o_pair1 = r_rd1;

endmodule

// ----- verif/stack_queue_heap_trace_classifier_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace classifier testbench
// Drives insert, remove, restart and unused requests into the classifier and
// checks every response against a behavioral model of the stack, the queue
// and the max priority queue, under varying source gaps and sink stalls.
// ----------------------------------------------------------------------------
module stack_queue_heap_trace_classifier_top_tb;
    import sqh_pkg::*;

    localparam int DEPTH           = 1024;
    localparam int VALUE_BITS      = 16;
    localparam int RANDOM_ITEMS    = 80;
    localparam int STALL_LIMIT     = 3000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PRESSURE_CYCLES = 600;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] t_val;

    typedef struct packed {
        logic [2:0] verdict;
        logic       stack_fits;
        logic       queue_fits;
        logic       heap_fits;
        logic       overflow;
    } t_status;

    class trace_verdict_board;
        t_val    stack_vals[$];
        t_val    queue_vals[$];
        // The priority queue is kept sorted with the largest value first.
        t_val    heap_vals[$];
        bit      stack_ok;
        bit      queue_ok;
        bit      heap_ok;
        bit      overflow_seen;
        t_status expected_status[$];
        int      errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            stack_vals.delete();
            queue_vals.delete();
            heap_vals.delete();
            stack_ok      = 1'b1;
            queue_ok      = 1'b1;
            heap_ok       = 1'b1;
            overflow_seen = 1'b0;
        endfunction

        function void insert_value(t_val v);
            int pos;
            if (stack_ok) begin
                if (stack_vals.size() >= DEPTH) overflow_seen = 1'b1;
                else stack_vals.push_back(v);
            end
            if (queue_ok) begin
                if (queue_vals.size() >= DEPTH) overflow_seen = 1'b1;
                else queue_vals.push_back(v);
            end
            if (heap_ok) begin
                if (heap_vals.size() >= DEPTH) begin
                    overflow_seen = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < heap_vals.size() && heap_vals[pos] >= v) pos++;
                    heap_vals.insert(pos, v);
                end
            end
        endfunction

        function void remove_value(t_val v);
            if (stack_ok) begin
                if (stack_vals.size() == 0 || stack_vals[stack_vals.size()-1] != v)
                    stack_ok = 1'b0;
                else
                    void'(stack_vals.pop_back());
            end
            if (queue_ok) begin
                if (queue_vals.size() == 0 || queue_vals[0] != v) queue_ok = 1'b0;
                else void'(queue_vals.pop_front());
            end
            if (heap_ok) begin
                if (heap_vals.size() == 0 || heap_vals[0] != v) heap_ok = 1'b0;
                else void'(heap_vals.pop_front());
            end
        endfunction

        function void note_request(logic [1:0] func, t_val v);
            t_status s;
            case (func)
                FUNC_INSERT:  insert_value(v);
                FUNC_REMOVE:  remove_value(v);
                FUNC_RESTART: restart();
                default: ;
            endcase
            s.stack_fits = stack_ok;
            s.queue_fits = queue_ok;
            s.heap_fits  = heap_ok;
            s.overflow   = overflow_seen;
            case ({heap_ok, queue_ok, stack_ok})
                3'b001:  s.verdict = VERDICT_STACK;
                3'b010:  s.verdict = VERDICT_QUEUE;
                3'b100:  s.verdict = VERDICT_HEAP;
                3'b000:  s.verdict = VERDICT_IMPOSSIBLE;
                default: s.verdict = VERDICT_UNSURE;
            endcase
            expected_status.push_back(s);
        endfunction

        function string show(t_status s);
            return $sformatf("verdict=%0d stack=%0b queue=%0b heap=%0b overflow=%0b",
                             s.verdict, s.stack_fits, s.queue_fits, s.heap_fits,
                             s.overflow);
        endfunction

        function void check_response(t_status got);
            t_status want;
            if (expected_status.size() == 0) begin
                $display("%0t: response with no request pending: %s", $time, show(got));
                errors++;
            end else begin
                want = expected_status.pop_front();
                if (got.verdict !== want.verdict || got.stack_fits !== want.stack_fits ||
                    got.queue_fits !== want.queue_fits || got.heap_fits !== want.heap_fits ||
                    got.overflow !== want.overflow) begin
                    $display("%0t: mismatch expected %s actual %s", $time, show(want),
                             show(got));
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    sqh_in_if #(.VB(VALUE_BITS)) in_ch ();
    sqh_out_if out_ch ();

    stack_queue_heap_trace_classifier_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    trace_verdict_board board;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int items_sent    = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if ($urandom_range(99) < sink_stall_pct) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.check_response({out_ch.verdict, out_ch.stack_fits, out_ch.queue_fits,
                                  out_ch.heap_fits, out_ch.overflow});
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_val pick_value();
        case ($urandom_range(3))
            0, 1: return t_val'($urandom_range(7));
            2:    return t_val'($urandom_range(16'hffff));
            default: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'hffff;
                    default: return 16'h0000;
                endcase
            end
        endcase
    endfunction

    task automatic send_request(input logic [1:0] func, input t_val v);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func  <= func;
        in_ch.value <= v;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        board.note_request(func, v);
        items_sent++;
    endtask

    // Inserts and removes that match the chosen structure, with some noise mixed in.
    task automatic run_trace(input int kind, input int len, input bit fresh);
        t_val shadow[$];
        t_val v;
        int   i;
        int   r;
        int   k;
        int   pos;
        int   best;
        if (fresh) send_request(FUNC_RESTART, pick_value());
        for (i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 4) begin
                send_request(FUNC_UNUSED, pick_value());
            end else if (r < 10) begin
                send_request(FUNC_REMOVE, pick_value());
            end else if (r < 55 || shadow.size() == 0) begin
                v = pick_value();
                shadow.push_back(v);
                send_request(FUNC_INSERT, v);
            end else begin
                k = (kind == 3) ? $urandom_range(2) : kind;
                case (k)
                    0: v = shadow.pop_back();
                    1: v = shadow.pop_front();
                    default: begin
                        best = 0;
                        for (pos = 1; pos < shadow.size(); pos++)
                            if (shadow[pos] > shadow[best]) best = pos;
                        v = shadow[best];
                        shadow.delete(best);
                    end
                endcase
                send_request(FUNC_REMOVE, v);
            end
        end
    endtask

    // Strictly falling values keep the queue and the priority queue in step
    // past the full store, so the queue ring wraps while both stay consistent.
    task automatic fill_past_depth();
        int k;
        send_request(FUNC_RESTART, 0);
        for (k = 0; k < DEPTH + 2; k++) send_request(FUNC_INSERT, t_val'(2000 - k));
        send_request(FUNC_REMOVE, 2000);
        for (k = 0; k < 8; k++) begin
            send_request(FUNC_INSERT, t_val'(2000 - (DEPTH + 2 + k)));
            send_request(FUNC_REMOVE, t_val'(1999 - k));
        end
        send_request(FUNC_RESTART, 0);
    endtask

    initial begin
        int  base;
        int  quarter;
        bit  pressure_done;
        board         = new();
        pressure_done = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_INSERT;
        in_ch.value   = '0;
        out_ch.ready  = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(FUNC_REMOVE, 5);
        send_request(FUNC_INSERT, 1);
        send_request(FUNC_UNUSED, 7);
        send_request(FUNC_RESTART, 0);
        send_request(FUNC_INSERT, 16'sh8000);
        send_request(FUNC_INSERT, 16'sh7fff);
        send_request(FUNC_INSERT, 0);
        send_request(FUNC_INSERT, -1);
        send_request(FUNC_REMOVE, -1);
        send_request(FUNC_REMOVE, 0);
        send_request(FUNC_REMOVE, 16'sh7fff);
        send_request(FUNC_REMOVE, 16'sh8000);
        send_request(FUNC_REMOVE, 3);
        send_request(FUNC_RESTART, 0);
        send_request(FUNC_INSERT, 3);
        send_request(FUNC_INSERT, 5);
        send_request(FUNC_INSERT, 4);
        send_request(FUNC_REMOVE, 3);
        send_request(FUNC_RESTART, 0);
        send_request(FUNC_INSERT, 3);
        send_request(FUNC_INSERT, 5);
        send_request(FUNC_INSERT, 4);
        send_request(FUNC_REMOVE, 5);
        send_request(FUNC_REMOVE, 4);
        send_request(FUNC_UNUSED, -1);

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            quarter = (items_sent - base) * 4 / RANDOM_ITEMS;
            case (quarter)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 22; sink_stall_pct = 22; end
            endcase
            if (quarter >= 2 && !pressure_done) begin
                stall_left    = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            run_trace($urandom_range(3), $urandom_range(1, 12), $urandom_range(9) != 0);
        end

        fill_past_depth();

        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
